// ===== hdl/qau_pkg.sv =====
// Package: operation codes and shared arithmetic for the quaternion unit.
package qau_pkg;

    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_MUL       = 4'd2,
        OP_SCALE     = 4'd3,
        OP_NEGATE    = 4'd4,
        OP_CONJ      = 4'd5,
        OP_DOT       = 4'd6,
        OP_NORM      = 4'd7,
        OP_INVERSE   = 4'd8,
        OP_NORMALISE = 4'd9,
        OP_ROTATE    = 4'd10
    } op_t;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int PW = 2 * DW + 4;

    typedef logic signed [DW-1:0] word_t;
    typedef logic signed [PW-1:0] wide_t;

    typedef struct packed {
        logic [3:0] op;
        word_t      aw;
        word_t      ax;
        word_t      ay;
        word_t      az;
        word_t      bw;
        word_t      bx;
        word_t      by;
        word_t      bz;
        word_t      s;
    } item_t;

    typedef struct packed {
        word_t rw;
        word_t rx;
        word_t ry;
        word_t rz;
        word_t sr;
        logic  err;
    } res_t;

    function automatic word_t sat(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = wide_t'((68'sd1 <<< (DW - 1)) - 68'sd1);
        lo = -hi - wide_t'(1);
        if (v > hi)
            sat = word_t'(hi);
        else if (v < lo)
            sat = word_t'(lo);
        else
            sat = v[DW-1:0];
    endfunction

    // arithmetic shift is a floor
    function automatic wide_t fshr(input wide_t v);
        fshr = v >>> FB;
    endfunction

endpackage

// ===== hdl/qau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module qau_div #(
    parameter int NW = 50,
    parameter int DDW = 40
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [NW-1:0]  num,
    input  logic [DDW-1:0] den,
    output logic [NW-1:0]  quo
);
    logic [NW-1:0]  q_reg [NW+1];
    logic [DDW:0]   r_reg [NW+1];
    logic [DDW-1:0] d_reg [NW+1];
    logic [NW-1:0]  n_reg [NW+1];

    always_comb
    begin
        q_reg[0] = '0;
        r_reg[0] = '0;
        d_reg[0] = den;
        n_reg[0] = num;
    end

    for (genvar i = 0; i < NW; i++)
    begin : g_st
        logic [DDW+1:0] t;
        logic [DDW+1:0] dd;
        logic [DDW+1:0] diff;
        always_comb
        begin
            t    = {r_reg[i], n_reg[i][NW-1-i]};
            dd   = {2'b00, d_reg[i]};
            diff = t - dd;
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                q_reg[i+1] <= '0;
                r_reg[i+1] <= '0;
                d_reg[i+1] <= '0;
                n_reg[i+1] <= '0;
            end
            else if (en)
            begin
                n_reg[i+1] <= n_reg[i];
                d_reg[i+1] <= d_reg[i];
                if (t >= dd)
                begin
                    r_reg[i+1] <= diff[DDW:0];
                    q_reg[i+1] <= q_reg[i] | (NW'(1) << (NW - 1 - i));
                end
                else
                begin
                    r_reg[i+1] <= t[DDW:0];
                    q_reg[i+1] <= q_reg[i];
                end
            end
        end
    end

    assign quo = q_reg[NW];
endmodule

// ===== hdl/quaternion_arithmetic_unit_core.sv =====
// Top level: pipelined Q16.16 quaternion arithmetic unit.
// Pipeline: 4 front stages, 34 root stages, 51 divider stages
// and the output register; one word per cycle when the output is taken.
// Depth set by the square-root stages (one result bit each) and the
// one-bit-per-stage dividers for inverse and normalise.
// A stall freezes the whole pipe; nothing is lost or repeated.
// Reset clears all valid bits asynchronously; no clearing pass.
module quaternion_arithmetic_unit_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar
    input  logic [287:0] s_tdata,
    // operation
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // r_w, r_x, r_y, r_z, scalar_result
    output logic [159:0] m_tdata,
    // error
    output logic         m_tuser
);
    localparam int DW = qau_pkg::DW;
    localparam int FB = qau_pkg::FB;
    localparam int SQ = 34;
    localparam int NWD = 51;
    localparam int DDW = 49;
    localparam int DEPTH = 4 + SQ + NWD + 1;

    logic en;
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [DEPTH-1:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DEPTH-2:0], s_tvalid};
    end
    assign m_tvalid = v_reg[DEPTH-1];

    qau_pkg::item_t in_i;
    assign in_i.op = s_tuser;
    assign in_i.aw = s_tdata[31:0];
    assign in_i.ax = s_tdata[63:32];
    assign in_i.ay = s_tdata[95:64];
    assign in_i.az = s_tdata[127:96];
    assign in_i.bw = s_tdata[159:128];
    assign in_i.bx = s_tdata[191:160];
    assign in_i.by = s_tdata[223:192];
    assign in_i.bz = s_tdata[255:224];
    assign in_i.s  = s_tdata[287:256];

    // stage 1: products
    qau_pkg::item_t i1_reg;
    qau_pkg::wide_t pr_reg [16];
    qau_pkg::wide_t sq_reg [4];
    qau_pkg::wide_t sc_reg [4];
    qau_pkg::wide_t cr_reg [6];
    qau_pkg::wide_t av_a[4], av_b[4];
    always_comb
    begin
        av_a = '{in_i.aw, in_i.ax, in_i.ay, in_i.az};
        av_b = '{in_i.bw, in_i.bx, in_i.by, in_i.bz};
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i1_reg <= in_i;
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                    pr_reg[i*4+j] <= av_a[i] * av_b[j];
                sq_reg[i] <= av_a[i] * av_a[i];
                sc_reg[i] <= av_a[i] * qau_pkg::wide_t'(in_i.s);
            end
        end
    end

    function automatic qau_pkg::wide_t fs2(input qau_pkg::wide_t p, input qau_pkg::wide_t q);
        fs2 = qau_pkg::fshr(p - q);
    endfunction

    // stage 2: sums, uv, norm
    qau_pkg::item_t i2_reg;
    qau_pkg::res_t  r2_reg;
    qau_pkg::word_t uv_reg [3];
    qau_pkg::word_t sc2_reg [4];
    logic [67:0]    n_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i2_reg <= i1_reg;
            n_reg <= 68'(sq_reg[0]) + 68'(sq_reg[1]) + 68'(sq_reg[2]) + 68'(sq_reg[3]);
            uv_reg[0] <= qau_pkg::sat(fs2(pr_reg[2*4+3], pr_reg[3*4+2]));
            uv_reg[1] <= qau_pkg::sat(fs2(pr_reg[3*4+1], pr_reg[1*4+3]));
            uv_reg[2] <= qau_pkg::sat(fs2(pr_reg[1*4+2], pr_reg[2*4+1]));
            r2_reg.err <= 1'b0;
            r2_reg.rw <= qau_pkg::sat(qau_pkg::fshr(pr_reg[0] - pr_reg[5] - pr_reg[10]
                - pr_reg[15]));
            r2_reg.rx <= qau_pkg::sat(qau_pkg::fshr(pr_reg[1] + pr_reg[4] + pr_reg[11]
                - pr_reg[14]));
            r2_reg.ry <= qau_pkg::sat(qau_pkg::fshr(pr_reg[2] + pr_reg[8] + pr_reg[13]
                - pr_reg[7]));
            r2_reg.rz <= qau_pkg::sat(qau_pkg::fshr(pr_reg[3] + pr_reg[12] + pr_reg[6]
                - pr_reg[9]));
            r2_reg.sr <= qau_pkg::sat(qau_pkg::fshr(pr_reg[0] + pr_reg[5] + pr_reg[10]
                + pr_reg[15]));
            for (int i = 0; i < 4; i++)
                sc2_reg[i] <= qau_pkg::sat(qau_pkg::fshr(sc_reg[i]));
        end
    end

    // stage 3: uuv and a_w*uv products
    qau_pkg::wide_t up_reg [9];
    qau_pkg::item_t i3_reg;
    qau_pkg::res_t  r3_reg;
    qau_pkg::word_t s3_reg [4];
    logic [67:0]    n3_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i3_reg <= i2_reg;
            r3_reg <= r2_reg;
            s3_reg <= sc2_reg;
            n3_reg <= n_reg;
            up_reg[0] <= i2_reg.ay * qau_pkg::wide_t'(uv_reg[2]);
            up_reg[1] <= i2_reg.az * qau_pkg::wide_t'(uv_reg[1]);
            up_reg[2] <= i2_reg.az * qau_pkg::wide_t'(uv_reg[0]);
            up_reg[3] <= i2_reg.ax * qau_pkg::wide_t'(uv_reg[2]);
            up_reg[4] <= i2_reg.ax * qau_pkg::wide_t'(uv_reg[1]);
            up_reg[5] <= i2_reg.ay * qau_pkg::wide_t'(uv_reg[0]);
            for (int i = 0; i < 3; i++)
                up_reg[6+i] <= i2_reg.aw * qau_pkg::wide_t'(uv_reg[i]);
        end
    end

    // stage 4: first result selection, then sqrt/div pipe
    qau_pkg::res_t pre;
    logic [3:0]    op4;
    always_comb
    begin
        pre = '0;
        op4 = i3_reg.op;
        unique case (op4) inside
            qau_pkg::OP_ADD:
            begin
                pre.rw = qau_pkg::sat(68'(i3_reg.aw) + 68'(i3_reg.bw));
                pre.rx = qau_pkg::sat(68'(i3_reg.ax) + 68'(i3_reg.bx));
                pre.ry = qau_pkg::sat(68'(i3_reg.ay) + 68'(i3_reg.by));
                pre.rz = qau_pkg::sat(68'(i3_reg.az) + 68'(i3_reg.bz));
            end
            qau_pkg::OP_SUB:
            begin
                pre.rw = qau_pkg::sat(68'(i3_reg.aw) - 68'(i3_reg.bw));
                pre.rx = qau_pkg::sat(68'(i3_reg.ax) - 68'(i3_reg.bx));
                pre.ry = qau_pkg::sat(68'(i3_reg.ay) - 68'(i3_reg.by));
                pre.rz = qau_pkg::sat(68'(i3_reg.az) - 68'(i3_reg.bz));
            end
            qau_pkg::OP_MUL:
            begin
                pre.rw = r3_reg.rw;
                pre.rx = r3_reg.rx;
                pre.ry = r3_reg.ry;
                pre.rz = r3_reg.rz;
            end
            qau_pkg::OP_SCALE:
            begin
                pre.rw = s3_reg[0];
                pre.rx = s3_reg[1];
                pre.ry = s3_reg[2];
                pre.rz = s3_reg[3];
            end
            qau_pkg::OP_NEGATE:
            begin
                pre.rw = qau_pkg::sat(-68'(i3_reg.aw));
                pre.rx = qau_pkg::sat(-68'(i3_reg.ax));
                pre.ry = qau_pkg::sat(-68'(i3_reg.ay));
                pre.rz = qau_pkg::sat(-68'(i3_reg.az));
            end
            qau_pkg::OP_CONJ:
            begin
                pre.rw = i3_reg.aw;
                pre.rx = qau_pkg::sat(-68'(i3_reg.ax));
                pre.ry = qau_pkg::sat(-68'(i3_reg.ay));
                pre.rz = qau_pkg::sat(-68'(i3_reg.az));
            end
            qau_pkg::OP_DOT: pre.sr = r3_reg.sr;
            qau_pkg::OP_NORM, qau_pkg::OP_INVERSE, qau_pkg::OP_NORMALISE:
                pre.sr = qau_pkg::sat(68'(n3_reg >> FB));
            qau_pkg::OP_ROTATE:
            begin
                pre.rx = qau_pkg::sat(68'(i3_reg.bx)
                    + 2 * qau_pkg::fshr(up_reg[6]) + 2 * fs2(up_reg[0], up_reg[1]));
                pre.ry = qau_pkg::sat(68'(i3_reg.by)
                    + 2 * qau_pkg::fshr(up_reg[7]) + 2 * fs2(up_reg[2], up_reg[3]));
                pre.rz = qau_pkg::sat(68'(i3_reg.bz)
                    + 2 * qau_pkg::fshr(up_reg[8]) + 2 * fs2(up_reg[4], up_reg[5]));
            end
            default: pre.err = 1'b1;
        endcase
        if (op4 == qau_pkg::OP_INVERSE)
            pre.sr = '0;
    end

    // delay line for item fields across sqrt and divide
    localparam int DL = SQ + NWD;
    qau_pkg::res_t  dr_reg [DL+1];
    qau_pkg::item_t di_reg [DL+1];
    logic [67:0]    dn_reg [SQ+1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dr_reg[0] <= pre;
            di_reg[0] <= i3_reg;
            dn_reg[0] <= n3_reg;
            for (int k = 0; k < DL; k++)
            begin
                dr_reg[k+1] <= dr_reg[k];
                di_reg[k+1] <= di_reg[k];
            end
            for (int k = 0; k < SQ; k++)
                dn_reg[k+1] <= dn_reg[k];
        end
    end

    // bit-serial integer square root, two radicand bits per stage
    logic [67:0] rm_reg [SQ+1];
    logic [34:0] rt_reg [SQ+1];
    always_comb
    begin
        rm_reg[0] = dn_reg[0];
        rt_reg[0] = '0;
    end
    for (genvar k = 0; k < SQ; k++)
    begin : g_sq
        logic [69:0] trial;
        logic [69:0] cur;
        always_comb
        begin
            cur   = {2'b00, rm_reg[k]} >> (2 * (SQ - 1 - k));
            trial = {33'd0, rt_reg[k], 2'b01};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ((cur & 70'h3f_ffff_ffff_ffff_ffff) >= (trial))
                begin
                    rm_reg[k+1] <= rm_reg[k] - 68'(trial << (2 * (SQ - 1 - k)));
                    rt_reg[k+1] <= {rt_reg[k][33:0], 1'b1};
                end
                else
                begin
                    rm_reg[k+1] <= rm_reg[k];
                    rt_reg[k+1] <= {rt_reg[k][33:0], 1'b0};
                end
            end
        end
    end

    // divisor choice and four dividers
    logic [3:0]  op_d;
    logic [DDW-1:0] den;
    logic [NWD-1:0] num [4];
    logic [NWD-1:0] quo [4];
    qau_pkg::word_t ca[4];
    always_comb
    begin
        op_d = di_reg[SQ].op;
        ca = '{di_reg[SQ].aw, di_reg[SQ].ax, di_reg[SQ].ay, di_reg[SQ].az};
        if (op_d == qau_pkg::OP_NORMALISE)
            den = DDW'(rt_reg[SQ]);
        else
            den = DDW'(dn_reg[SQ] >> FB);
        for (int i = 0; i < 4; i++)
            num[i] = NWD'(ca[i][DW-1] ? -33'(ca[i]) : 33'(ca[i])) << FB;
    end
    for (genvar i = 0; i < 4; i++)
    begin : g_dv
        qau_div #(.NW(NWD), .DDW(DDW)) u_div (
            .clk(clk), .rst_n(rst_n), .en(en), .num(num[i]), .den(den), .quo(quo[i])
        );
    end

    // final stage
    qau_pkg::res_t out_reg;
    qau_pkg::res_t fin;
    qau_pkg::item_t fi;
    logic zero_a, dz;
    qau_pkg::word_t fa[4];
    qau_pkg::wide_t qv;
    logic ng;
    always_comb
    begin
        fin = dr_reg[DL];
        fi = di_reg[DL];
        fa = '{fi.aw, fi.ax, fi.ay, fi.az};
        zero_a = (fi.aw == 0) && (fi.ax == 0) && (fi.ay == 0) && (fi.az == 0);
        qv = '0;
        ng = 1'b0;
        dz = 1'b0;
        if (fi.op == qau_pkg::OP_INVERSE || fi.op == qau_pkg::OP_NORMALISE)
        begin
            if (zero_a)
            begin
                fin = '0;
                fin.err = 1'b1;
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ng = fa[i][DW-1] ^ (fi.op == qau_pkg::OP_INVERSE && i != 0);
                    qv = qau_pkg::wide_t'({17'd0, quo[i]});
                    dz = (fi.op == qau_pkg::OP_INVERSE) && (quo[i] == '1);
                    if (dz || qv > (68'sd1 <<< 62))
                        qv = 68'sd1 <<< 62;
                    if (fa[i] == 0)
                        qv = '0;
                    case (i)
                        0: fin.rw = qau_pkg::sat(ng ? -qv : qv);
                        1: fin.rx = qau_pkg::sat(ng ? -qv : qv);
                        2: fin.ry = qau_pkg::sat(ng ? -qv : qv);
                        default: fin.rz = qau_pkg::sat(ng ? -qv : qv);
                    endcase
                end
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= fin;
    end

    assign m_tdata = {out_reg.sr, out_reg.rz, out_reg.ry, out_reg.rx, out_reg.rw};
    assign m_tuser = out_reg.err;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error word not zero");
endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the Q16.16 quaternion arithmetic unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [129:0] big_t;

    typedef struct {
        qau_pkg::item_t it;
        bit             typed;
        qau_pkg::res_t  want;
    } row_t;

    localparam qau_pkg::word_t WMAX = 32'sh7fffffff;
    localparam qau_pkg::word_t WMIN = 32'sh80000000;
    localparam qau_pkg::word_t ONE  = 32'sh00010000;
    localparam int    WATCHDOG = 4000;
    localparam int    N_RANDOM = 1230;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic [3:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;
    logic         m_tuser;

    qau_pkg::res_t pending_results[$];
    int   mismatches;
    int   accepted_in;
    int   checked_out;
    int   stall_cycles;
    int   op_seen[16];
    bit   calm_window;
    bit   hold_request;
    bit   hold_done;

    quaternion_arithmetic_unit_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic qau_pkg::word_t clamp32(input big_t v);
        if (v > big_t'(WMAX))
            return WMAX;
        if (v < big_t'(WMIN))
            return WMIN;
        return qau_pkg::word_t'(v[31:0]);
    endfunction

    function automatic big_t prod(input qau_pkg::word_t p, input qau_pkg::word_t q);
        return big_t'(p) * big_t'(q);
    endfunction

    // x * 2^F / d truncated towards zero, optional sign flip
    function automatic qau_pkg::word_t qdiv(input qau_pkg::word_t x, input big_t d,
                                            input bit flip);
        big_t mag;
        big_t q;
        bit   neg;
        mag = (x < 0) ? -big_t'(x) : big_t'(x);
        neg = (x < 0) ^ flip;
        if (mag == 0)
            return '0;
        q = (d == 0) ? (big_t'(1) <<< 62) : ((mag <<< qau_pkg::FB) / d);
        return clamp32(neg ? -q : q);
    endfunction

    function automatic big_t root_floor(input big_t n);
        big_t r;
        big_t t;
        r = 0;
        for (int i = 33; i >= 0; i--)
        begin
            t = r | (big_t'(1) <<< i);
            if (t * t <= n)
                r = t;
        end
        return r;
    endfunction

    function automatic qau_pkg::res_t quat_result(input qau_pkg::item_t it);
        qau_pkg::res_t  r;
        big_t           n;
        big_t           len;
        qau_pkg::word_t uv[3];
        big_t           uu[3];
        qau_pkg::word_t a[4];
        qau_pkg::word_t b[4];
        a = '{it.aw, it.ax, it.ay, it.az};
        b = '{it.bw, it.bx, it.by, it.bz};
        r = '0;
        n = prod(a[0], a[0]) + prod(a[1], a[1]) + prod(a[2], a[2]) + prod(a[3], a[3]);
        case (it.op)
            qau_pkg::OP_ADD:
            begin
                r.rw = clamp32(big_t'(a[0]) + big_t'(b[0]));
                r.rx = clamp32(big_t'(a[1]) + big_t'(b[1]));
                r.ry = clamp32(big_t'(a[2]) + big_t'(b[2]));
                r.rz = clamp32(big_t'(a[3]) + big_t'(b[3]));
            end
            qau_pkg::OP_SUB:
            begin
                r.rw = clamp32(big_t'(a[0]) - big_t'(b[0]));
                r.rx = clamp32(big_t'(a[1]) - big_t'(b[1]));
                r.ry = clamp32(big_t'(a[2]) - big_t'(b[2]));
                r.rz = clamp32(big_t'(a[3]) - big_t'(b[3]));
            end
            qau_pkg::OP_MUL:
            begin
                r.rw = clamp32((prod(a[0], b[0]) - prod(a[1], b[1]) - prod(a[2], b[2])
                               - prod(a[3], b[3])) >>> qau_pkg::FB);
                r.rx = clamp32((prod(a[0], b[1]) + prod(a[1], b[0]) + prod(a[2], b[3])
                               - prod(a[3], b[2])) >>> qau_pkg::FB);
                r.ry = clamp32((prod(a[0], b[2]) + prod(a[2], b[0]) + prod(a[3], b[1])
                               - prod(a[1], b[3])) >>> qau_pkg::FB);
                r.rz = clamp32((prod(a[0], b[3]) + prod(a[3], b[0]) + prod(a[1], b[2])
                               - prod(a[2], b[1])) >>> qau_pkg::FB);
            end
            qau_pkg::OP_SCALE:
            begin
                r.rw = clamp32(prod(it.s, a[0]) >>> qau_pkg::FB);
                r.rx = clamp32(prod(it.s, a[1]) >>> qau_pkg::FB);
                r.ry = clamp32(prod(it.s, a[2]) >>> qau_pkg::FB);
                r.rz = clamp32(prod(it.s, a[3]) >>> qau_pkg::FB);
            end
            qau_pkg::OP_NEGATE:
            begin
                r.rw = clamp32(-big_t'(a[0]));
                r.rx = clamp32(-big_t'(a[1]));
                r.ry = clamp32(-big_t'(a[2]));
                r.rz = clamp32(-big_t'(a[3]));
            end
            qau_pkg::OP_CONJ:
            begin
                r.rw = a[0];
                r.rx = clamp32(-big_t'(a[1]));
                r.ry = clamp32(-big_t'(a[2]));
                r.rz = clamp32(-big_t'(a[3]));
            end
            qau_pkg::OP_DOT:
                r.sr = clamp32((prod(a[0], b[0]) + prod(a[1], b[1]) + prod(a[2], b[2])
                               + prod(a[3], b[3])) >>> qau_pkg::FB);
            qau_pkg::OP_NORM:
                r.sr = clamp32(n >>> qau_pkg::FB);
            qau_pkg::OP_INVERSE:
            begin
                if (n == 0)
                    r.err = 1'b1;
                else
                begin
                    r.rw = qdiv(a[0], n >>> qau_pkg::FB, 1'b0);
                    r.rx = qdiv(a[1], n >>> qau_pkg::FB, 1'b1);
                    r.ry = qdiv(a[2], n >>> qau_pkg::FB, 1'b1);
                    r.rz = qdiv(a[3], n >>> qau_pkg::FB, 1'b1);
                end
            end
            qau_pkg::OP_NORMALISE:
            begin
                len = root_floor(n);
                r.sr = clamp32(n >>> qau_pkg::FB);
                if (len == 0)
                    r.err = 1'b1;
                else
                begin
                    r.rw = qdiv(a[0], len, 1'b0);
                    r.rx = qdiv(a[1], len, 1'b0);
                    r.ry = qdiv(a[2], len, 1'b0);
                    r.rz = qdiv(a[3], len, 1'b0);
                end
            end
            qau_pkg::OP_ROTATE:
            begin
                uv[0] = clamp32((prod(a[2], b[3]) - prod(a[3], b[2])) >>> qau_pkg::FB);
                uv[1] = clamp32((prod(a[3], b[1]) - prod(a[1], b[3])) >>> qau_pkg::FB);
                uv[2] = clamp32((prod(a[1], b[2]) - prod(a[2], b[1])) >>> qau_pkg::FB);
                uu[0] = (prod(a[2], uv[2]) - prod(a[3], uv[1])) >>> qau_pkg::FB;
                uu[1] = (prod(a[3], uv[0]) - prod(a[1], uv[2])) >>> qau_pkg::FB;
                uu[2] = (prod(a[1], uv[1]) - prod(a[2], uv[0])) >>> qau_pkg::FB;
                r.rx = clamp32(big_t'(b[1]) + 2 * (prod(a[0], uv[0]) >>> qau_pkg::FB)
                               + 2 * uu[0]);
                r.ry = clamp32(big_t'(b[2]) + 2 * (prod(a[0], uv[1]) >>> qau_pkg::FB)
                               + 2 * uu[1]);
                r.rz = clamp32(big_t'(b[3]) + 2 * (prod(a[0], uv[2]) >>> qau_pkg::FB)
                               + 2 * uu[2]);
            end
            default:
                r.err = 1'b1;
        endcase
        return r;
    endfunction

    function automatic qau_pkg::word_t rand_word();
        case ($urandom_range(9))
            0, 1, 2, 3: return qau_pkg::word_t'($urandom);
            4, 5, 6:    return qau_pkg::word_t'(int'($urandom_range(524288)) - 262144);
            7:          return $urandom_range(1) ? WMAX : WMIN;
            8:          return qau_pkg::word_t'(int'($urandom_range(511)) - 256);
            default:    return '0;
        endcase
    endfunction

    function automatic qau_pkg::item_t rand_item();
        qau_pkg::item_t it;
        it.op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11))
                                          : 4'($urandom_range(10));
        it.aw = rand_word();
        it.ax = rand_word();
        it.ay = rand_word();
        it.az = rand_word();
        it.bw = rand_word();
        it.bx = rand_word();
        it.by = rand_word();
        it.bz = rand_word();
        it.s  = rand_word();
        if ((it.op == qau_pkg::OP_INVERSE || it.op == qau_pkg::OP_NORMALISE)
            && $urandom_range(14) == 0)
        begin
            it.aw = '0;
            it.ax = '0;
            it.ay = '0;
            it.az = '0;
        end
        return it;
    endfunction

    function automatic row_t mk(input qau_pkg::op_t op, input qau_pkg::word_t aw,
                                input qau_pkg::word_t ax, input qau_pkg::word_t ay,
                                input qau_pkg::word_t az, input qau_pkg::word_t bw,
                                input qau_pkg::word_t bx, input qau_pkg::word_t by,
                                input qau_pkg::word_t bz, input qau_pkg::word_t s);
        row_t r;
        r.it    = '{op: op, aw: aw, ax: ax, ay: ay, az: az, bw: bw, bx: bx, by: by,
                    bz: bz, s: s};
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    task automatic send_word(input qau_pkg::item_t it, input qau_pkg::res_t want);
        s_tdata  <= {it.s, it.bz, it.by, it.bx, it.bw, it.az, it.ay, it.ax, it.aw};
        s_tuser  <= it.op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(want);
        op_seen[it.op]++;
        accepted_in++;
    endtask

    task automatic maybe_idle();
        if (!calm_window && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    initial
    begin
        row_t           dir[$];
        row_t           r;
        qau_pkg::item_t it;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        mismatches   = 0;
        accepted_in  = 0;
        checked_out  = 0;
        calm_window  = 1'b0;
        hold_request = 1'b0;

        r = mk(qau_pkg::OP_ADD, WMAX, WMIN, ONE, 0, WMAX, WMIN, ONE, 0, 0);
        r.typed = 1'b1;
        r.want = '{rw: WMAX, rx: WMIN, ry: 32'sh20000, rz: 0, sr: 0, err: 0};
        dir.push_back(r);
        r = mk(qau_pkg::OP_SUB, WMIN, WMAX, 0, -1, WMAX, WMIN, 0, 1, 0);
        r.typed = 1'b1;
        r.want = '{rw: WMIN, rx: WMAX, ry: 0, rz: -2, sr: 0, err: 0};
        dir.push_back(r);
        dir.push_back(mk(qau_pkg::OP_MUL, ONE, ONE, ONE, ONE, ONE, -ONE, ONE, -ONE, 0));
        dir.push_back(mk(qau_pkg::OP_MUL, WMAX, WMIN, WMAX, WMIN, WMIN, WMIN, WMAX, WMAX,
                         0));
        dir.push_back(mk(qau_pkg::OP_SCALE, -1, WMAX, WMIN, ONE, 0, 0, 0, 0, -ONE));
        dir.push_back(mk(qau_pkg::OP_SCALE, WMAX, WMIN, 3, -3, 0, 0, 0, 0, WMIN));
        r = mk(qau_pkg::OP_NEGATE, WMIN, WMAX, 0, 1, 0, 0, 0, 0, 0);
        r.typed = 1'b1;
        r.want = '{rw: WMAX, rx: -WMAX, ry: 0, rz: -1, sr: 0, err: 0};
        dir.push_back(r);
        dir.push_back(mk(qau_pkg::OP_CONJ, WMIN, WMIN, WMAX, -5, 0, 0, 0, 0, 0));
        dir.push_back(mk(qau_pkg::OP_DOT, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX,
                         0));
        dir.push_back(mk(qau_pkg::OP_DOT, ONE, -ONE, 7, -7, ONE, ONE, 3, 3, 0));
        r = mk(qau_pkg::OP_NORM, WMIN, WMIN, WMIN, WMIN, 0, 0, 0, 0, 0);
        r.typed = 1'b1;
        r.want = '{rw: 0, rx: 0, ry: 0, rz: 0, sr: WMAX, err: 0};
        dir.push_back(r);
        dir.push_back(mk(qau_pkg::OP_NORM, ONE, ONE, 0, 0, 0, 0, 0, 0, 0));
        r = mk(qau_pkg::OP_INVERSE, 0, 0, 0, 0, 5, 5, 5, 5, 5);
        r.typed = 1'b1;
        r.want = '{rw: 0, rx: 0, ry: 0, rz: 0, sr: 0, err: 1};
        dir.push_back(r);
        dir.push_back(mk(qau_pkg::OP_INVERSE, 32'sh20000, ONE, 0, -ONE, 0, 0, 0, 0, 0));
        // nonzero but the floored norm is zero
        dir.push_back(mk(qau_pkg::OP_INVERSE, 5, -3, 0, 1, 0, 0, 0, 0, 0));
        dir.push_back(mk(qau_pkg::OP_INVERSE, WMIN, WMIN, WMIN, WMIN, 0, 0, 0, 0, 0));
        r = mk(qau_pkg::OP_NORMALISE, 0, 0, 0, 0, 1, 1, 1, 1, 1);
        r.typed = 1'b1;
        r.want = '{rw: 0, rx: 0, ry: 0, rz: 0, sr: 0, err: 1};
        dir.push_back(r);
        dir.push_back(mk(qau_pkg::OP_NORMALISE, 32'sh30000, 32'sh40000, 0, 0, 0, 0, 0, 0,
                         0));
        dir.push_back(mk(qau_pkg::OP_NORMALISE, WMIN, WMIN, WMIN, WMIN, 0, 0, 0, 0, 0));
        dir.push_back(mk(qau_pkg::OP_NORMALISE, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(qau_pkg::OP_ROTATE, 32'sh0b505, 0, 0, 32'sh0b505, 0, ONE, 0, 0,
                         0));
        dir.push_back(mk(qau_pkg::OP_ROTATE, WMAX, WMIN, WMAX, WMIN, 0, WMAX, WMIN, WMAX,
                         0));
        r = mk(qau_pkg::OP_ADD, 1, 2, 3, 4, 5, 6, 7, 8, 9);
        r.it.op = 4'd15;
        r.typed = 1'b1;
        r.want = '{rw: 0, rx: 0, ry: 0, rz: 0, sr: 0, err: 1};
        dir.push_back(r);
        r.it.op = 4'd11;
        dir.push_back(r);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[i])
        begin
            send_word(dir[i].it, dir[i].typed ? dir[i].want : quat_result(dir[i].it));
            maybe_idle();
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm_window = (i >= 500 && i < 650);
            if (i == 300)
            begin
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            if (i == 800)
                hold_request = 1'b1;
            it = rand_item();
            send_word(it, quat_result(it));
            maybe_idle();
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        $display("tb: %0d words in, %0d results checked, %0d mismatches", accepted_in,
                 checked_out, mismatches);
        $display("tb: ops add..rotate %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d, bad %0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
                 op_seen[6], op_seen[7], op_seen[8], op_seen[9], op_seen[10],
                 op_seen[11] + op_seen[12] + op_seen[13] + op_seen[14] + op_seen[15]);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // receiver: random back-pressure, one long hold-off
    initial
    begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            m_tready <= calm_window ? 1'b1 : ($urandom_range(99) >= 22);
        end
    end

    always @(posedge clk)
    begin
        qau_pkg::res_t want;
        qau_pkg::res_t got;
        if (m_tvalid && m_tready && rst_n)
        begin
            got = '{rw: m_tdata[31:0], rx: m_tdata[63:32], ry: m_tdata[95:64],
                    rz: m_tdata[127:96], sr: m_tdata[159:128], err: m_tuser};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected result word %h err %b", m_tdata, m_tuser);
            end
            else
            begin
                want = pending_results.pop_front();
                checked_out++;
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("tb: mismatch #%0d exp w %h x %h y %h z %h s %h e %b",
                                 checked_out, want.rw, want.rx, want.ry, want.rz,
                                 want.sr, want.err);
                        $display("tb:   got w %h x %h y %h z %h s %h e %b",
                                 got.rw, got.rx, got.ry, got.rz, got.sr, got.err);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG)
        begin
            $display("tb: timeout, %0d results outstanding", pending_results.size());
            $display("tb: FAIL");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
hdl/qau_pkg.sv
hdl/qau_div.sv
hdl/quaternion_arithmetic_unit_core.sv
dv/tb.sv
